>>> design/ppfc_pkg.sv
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types and constants of the predictive PFC duty controller.
// ----------------------------------------------------------------------------
`default_nettype none

package ppfc_pkg;

   localparam int DATA_W   = 24;
   localparam int ANGLE_W  = 16;
   localparam int RATIO_W  = 32;
   localparam int DUTY_W   = 32;
   localparam int REQ_W    = 112;
   localparam int CSR_IDX_W = 3;

   localparam int ZW       = 15;
   localparam int EMAG_W   = 30;
   localparam int SUMH_W   = 42;
   localparam int NUM_W    = 62;
   localparam int QUO_W    = 62;
   localparam int ACC_W    = 62;
   localparam int MUL_A_W  = 52;
   localparam int MUL_B_W  = 19;
   localparam int MUL_P_W  = 71;
   localparam int DIV_CNT_W = 5;
   localparam int DIV_STEPS = 31;

   localparam logic [15:0] SIN_A       = 16'd25736;
   localparam logic [15:0] SIN_B       = 16'd10512;
   localparam logic [15:0] SIN_C       = 16'd1160;
   localparam logic [15:0] GAIN_FIFTH  = 16'd17695;
   localparam logic [15:0] PROP_COEF   = 16'd22938;
   localparam logic [17:0] DAMP_COEF   = 18'd251658;
   localparam logic [23:0] ONE_Q12     = 24'd4096;
   localparam logic [14:0] QUARTER     = 15'd16384;

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP3    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP5    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP7    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE3  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE5  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE7  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_HARM_EN = 3'd7;

   localparam logic [1:0] HSEL_THIRD   = 2'd0;
   localparam logic [1:0] HSEL_FIFTH   = 2'd1;
   localparam logic [1:0] HSEL_SEVENTH = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_SIN0,
      OP_SIN1,
      OP_SIN2,
      OP_SIN3,
      OP_SIN4,
      OP_SIN5,
      OP_HGAIN,
      OP_HACC,
      OP_ERR,
      OP_MLO,
      OP_RLO,
      OP_RHI,
      OP_DFF_GET,
      OP_COR_GET,
      OP_COR,
      OP_DMP_ST,
      OP_DMP_GET
   } op_type;

   typedef struct packed {
      logic       load;
      logic       fire;
      op_type     op;
      logic [1:0] hsel;
   } cmd_type;

   typedef struct packed {
      logic harm_en;
      logic div_done;
      logic out_full;
   } stat_type;

   typedef struct packed {
      logic [RATIO_W-1:0]        ratio;
      logic signed [DATA_W-1:0]  amp3;
      logic signed [DATA_W-1:0]  amp5;
      logic signed [DATA_W-1:0]  amp7;
      logic [ANGLE_W-1:0]        phase3;
      logic [ANGLE_W-1:0]        phase5;
      logic [ANGLE_W-1:0]        phase7;
      logic                      harm_en;
   } cfg_type;

endpackage

`default_nettype wire

>>> design/ppfc_div.sv
// ----------------------------------------------------------------------------
// ppfc_div
// Radix-4 restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_div
   import ppfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DATA_W-1:0] den,
   output logic                   done,
   output logic [QUO_W-1:0]       quo
);

   logic [NUM_W-1:0]     work_ff, work_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DATA_W:0]   r1, r2;
   logic              ge1, ge2;
   logic [DATA_W-1:0] r1n, r2n;
   logic [NUM_W-1:0]  w1, w2;

   always_comb begin
      r1  = {rem_ff, work_ff[NUM_W-1]};
      ge1 = (r1 >= {1'b0, den_ff});
      r1n = ge1 ? DATA_W'(r1 - {1'b0, den_ff}) : r1[DATA_W-1:0];
      w1  = {work_ff[NUM_W-2:0], ge1};
      r2  = {r1n, w1[NUM_W-1]};
      ge2 = (r2 >= {1'b0, den_ff});
      r2n = ge2 ? DATA_W'(r2 - {1'b0, den_ff}) : r2[DATA_W-1:0];
      w2  = {w1[NUM_W-2:0], ge2};

      work_in = work_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         work_in = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         work_in = w2;
         rem_in  = r2n;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = work_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff && !done_ff)
      else $error("divider did not start");

   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) |=> done_ff)
      else $error("divider missed its last step");

endmodule

`default_nettype wire

>>> design/ppfc_dpath.sv
// ----------------------------------------------------------------------------
// ppfc_dpath
// Datapath: input capture, shared multiplier, sine steps, divider and output.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_dpath
   import ppfc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire cfg_type           cfg,
   input  wire logic [REQ_W-1:0]  req_data,
   output logic [DUTY_W-1:0]      rsp_tdata,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output stat_type               stat
);

   logic signed [DATA_W-1:0] il_ff;
   logic                     pos_ff;
   logic [DATA_W-1:0]        iref_mag_ff, vin_mag_ff, vo_ff, ilsafe_ff;
   logic [ANGLE_W-1:0]       lead_ff, prev_ff, prev_in;
   logic                     seen_ff;
   logic [ZW-1:0]            z_ff, z2_ff;
   logic                     neg_ff;
   logic signed [SUMH_W-1:0] sum_ff;
   logic [EMAG_W-1:0]        emag_ff;
   logic                     esign_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic signed [ACC_W-1:0]  dff_ff, corr_ff;
   logic signed [MUL_P_W-1:0] p_ff;
   logic [DUTY_W-1:0]        duty_ff;
   logic                     valid_ff;

   logic signed [DATA_W-1:0] in_il, in_iref, in_vin, in_vo;
   logic [ANGLE_W-1:0]       in_grid, prev_eff;
   logic [DATA_W-1:0]        iref_mag, vin_mag, vo_mag, il_mag;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic [ANGLE_W-1:0]       ang, hphase;
   logic [DATA_W-1:0]        amp_mag;
   logic signed [DATA_W-1:0] amp_sel;
   logic [15:0]              tval, sval;
   logic signed [16:0]       s_signed;
   logic signed [MUL_P_W-1:0] p_sh14;
   logic signed [30:0]       ref_w, err_w;
   logic signed [SUMH_W-1:0] sum_sh;

   logic                     div_start, div_done;
   logic [NUM_W-1:0]         div_num;
   logic [DATA_W-1:0]        div_den;
   logic [QUO_W-1:0]         div_quo;

   logic signed [ACC_W-1:0]  damp_s, corr_s, total;
   logic [DUTY_W-1:0]        duty_sat;

   function automatic logic [DATA_W-1:0] mag24(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   ppfc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      in_il    = req_data[23:0];
      in_iref  = req_data[47:24];
      in_vin   = req_data[71:48];
      in_vo    = req_data[95:72];
      in_grid  = req_data[111:96];
      iref_mag = mag24(in_iref);
      vin_mag  = mag24(in_vin);
      vo_mag   = mag24(in_vo);
      il_mag   = mag24(in_il);
      prev_eff = seen_ff ? prev_ff : in_grid;
      prev_in  = (cfg.harm_en || !seen_ff) ? in_grid : prev_ff;

      case (cmd.hsel)
         HSEL_THIRD: begin
            ang     = ANGLE_W'(lead_ff * 3);
            hphase  = cfg.phase3;
            amp_sel = cfg.amp3;
         end
         HSEL_FIFTH: begin
            ang     = ANGLE_W'(lead_ff * 5);
            hphase  = cfg.phase5;
            amp_sel = cfg.amp5;
         end
         default: begin
            ang     = ANGLE_W'(lead_ff * 7);
            hphase  = cfg.phase7;
            amp_sel = cfg.amp7;
         end
      endcase
      ang     = ang + hphase;
      amp_mag = mag24(amp_sel);

      p_sh14   = p_ff >>> 14;
      sval     = p_ff[29:14];
      s_signed = neg_ff ? -$signed({1'b0, sval}) : $signed({1'b0, sval});
      tval     = 16'h0000;
      mul_a    = '0;
      mul_b    = '0;
      case (cmd.op)
         OP_SIN1: begin
            mul_a = $signed({37'b0, z_ff});
            mul_b = $signed({4'b0, z_ff});
         end
         OP_SIN2: begin
            mul_a = $signed({37'b0, p_ff[28:14]});
            mul_b = $signed({3'b0, SIN_C});
         end
         OP_SIN3: begin
            tval  = SIN_B - p_ff[29:14];
            mul_a = $signed({36'b0, tval});
            mul_b = $signed({4'b0, z2_ff});
         end
         OP_SIN4: begin
            tval  = SIN_A - p_ff[29:14];
            mul_a = $signed({36'b0, tval});
            mul_b = $signed({4'b0, z_ff});
         end
         OP_SIN5: begin
            mul_a = $signed({28'b0, amp_mag});
            mul_b = MUL_B_W'(s_signed);
         end
         OP_HGAIN: begin
            mul_a = MUL_A_W'($signed(p_ff[38:0]));
            mul_b = $signed({3'b0, GAIN_FIFTH});
         end
         OP_MLO: begin
            mul_a = $signed({22'b0, emag_ff});
            mul_b = $signed({3'b0, cfg.ratio[15:0]});
         end
         OP_RLO: begin
            mul_a = $signed({22'b0, emag_ff});
            mul_b = $signed({3'b0, cfg.ratio[31:16]});
         end
         OP_COR_GET: begin
            mul_a = $signed({1'b0, div_quo[50:0]});
            mul_b = $signed({3'b0, PROP_COEF});
         end
         OP_COR: begin
            mul_a = $signed({22'b0, emag_ff});
            mul_b = $signed({1'b0, DAMP_COEF});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;

      sum_sh = SUMH_W'(sum_ff >>> 14);
      ref_w  = pos_ff ? $signed({7'b0, iref_mag_ff}) : -$signed({7'b0, iref_mag_ff});
      if (cfg.harm_en) begin
         ref_w = ref_w - 31'(sum_sh);
      end
      err_w = ref_w - 31'(il_ff);

      div_start = 1'b0;
      div_num   = '0;
      div_den   = vo_ff;
      if (cmd.fire) begin
         case (cmd.op)
            OP_MLO: begin
               div_start = 1'b1;
               div_num   = NUM_W'({vin_mag_ff, 24'b0});
            end
            OP_DFF_GET: begin
               div_start = 1'b1;
               div_num   = acc_ff;
            end
            OP_DMP_ST: begin
               div_start = 1'b1;
               div_num   = p_ff[NUM_W-1:0];
               div_den   = ilsafe_ff;
            end
            default: begin
               div_start = 1'b0;
            end
         endcase
      end

      damp_s = $signed(div_quo);
      corr_s = corr_ff;
      if (!esign_ff) begin
         damp_s = -damp_s;
         corr_s = -corr_s;
      end
      total = dff_ff + corr_s + damp_s;
      if (total > 62'sd2147483647) begin
         duty_sat = 32'h7FFF_FFFF;
      end else if (total < -62'sd2147483648) begin
         duty_sat = 32'h8000_0000;
      end else begin
         duty_sat = total[DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         il_ff       <= in_il;
         pos_ff      <= !in_vin[DATA_W-1] && (in_vin != '0);
         iref_mag_ff <= iref_mag;
         vin_mag_ff  <= vin_mag;
         vo_ff       <= (vo_mag < ONE_Q12) ? ONE_Q12 : vo_mag;
         ilsafe_ff   <= (il_mag == '0) ? DATA_W'(1) : il_mag;
         lead_ff     <= in_grid + (in_grid - prev_eff);
         sum_ff      <= '0;
      end
      if (cmd.fire) begin
         p_ff <= mul_p;
         case (cmd.op)
            OP_SIN0: begin
               z_ff   <= ang[14] ? QUARTER - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
               neg_ff <= ang[15];
            end
            OP_SIN2: z2_ff <= p_ff[28:14];
            OP_HACC: begin
               if (cmd.hsel == HSEL_FIFTH) begin
                  sum_ff <= sum_ff + p_sh14[SUMH_W-1:0];
               end else begin
                  sum_ff <= sum_ff + p_ff[SUMH_W-1:0];
               end
            end
            OP_ERR: begin
               emag_ff  <= err_w[30] ? EMAG_W'(-err_w) : EMAG_W'(err_w);
               esign_ff <= (!err_w[30]) == pos_ff;
            end
            OP_RLO: acc_ff <= p_ff[ACC_W-1:0];
            OP_RHI: acc_ff <= acc_ff + ACC_W'({p_ff[45:0], 16'b0});
            OP_DFF_GET: dff_ff <= $signed(ACC_W'(1) <<< 24) - $signed(div_quo);
            OP_COR: corr_ff <= p_ff[69:8];
            OP_DMP_GET: duty_ff <= duty_sat;
            default: begin
            end
         endcase
      end
      if (reset) begin
         prev_ff  <= '0;
         seen_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            prev_ff <= prev_in;
            seen_ff <= 1'b1;
         end
         if (cmd.fire && cmd.op == OP_DMP_GET) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tdata     = duty_ff;
   assign rsp_tvalid    = valid_ff;
   assign stat.harm_en  = cfg.harm_en;
   assign stat.div_done = div_done;
   assign stat.out_full = valid_ff && !rsp_tready;

endmodule

`default_nettype wire

>>> design/ppfc_ctrl.sv
// ----------------------------------------------------------------------------
// ppfc_ctrl
// Sequencer: steps the datapath through one sample's operations.
// ----------------------------------------------------------------------------
`default_nettype none

module ppfc_ctrl
   import ppfc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type  state_ff;
   op_type     op_ff, op_in;
   logic [1:0] hsel_ff, hsel_in;
   logic       stall, accept;

   always_comb begin
      accept = (state_ff == ST_IDLE) && req_tvalid;
      case (op_ff)
         OP_DFF_GET, OP_COR_GET: stall = !stat.div_done;
         OP_DMP_GET:             stall = !stat.div_done || stat.out_full;
         default:                stall = 1'b0;
      endcase

      hsel_in = hsel_ff;
      case (op_ff)
         OP_SIN0:    op_in = OP_SIN1;
         OP_SIN1:    op_in = OP_SIN2;
         OP_SIN2:    op_in = OP_SIN3;
         OP_SIN3:    op_in = OP_SIN4;
         OP_SIN4:    op_in = OP_SIN5;
         OP_SIN5:    op_in = (hsel_ff == HSEL_FIFTH) ? OP_HGAIN : OP_HACC;
         OP_HGAIN:   op_in = OP_HACC;
         OP_HACC: begin
            if (hsel_ff == HSEL_SEVENTH) begin
               op_in = OP_ERR;
            end else begin
               op_in   = OP_SIN0;
               hsel_in = hsel_ff + 1'b1;
            end
         end
         OP_ERR:     op_in = OP_MLO;
         OP_MLO:     op_in = OP_RLO;
         OP_RLO:     op_in = OP_RHI;
         OP_RHI:     op_in = OP_DFF_GET;
         OP_DFF_GET: op_in = OP_COR_GET;
         OP_COR_GET: op_in = OP_COR;
         OP_COR:     op_in = OP_DMP_ST;
         OP_DMP_ST:  op_in = OP_DMP_GET;
         default:    op_in = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_NONE;
         hsel_ff  <= HSEL_THIRD;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RUN;
                  hsel_ff  <= HSEL_THIRD;
                  op_ff    <= stat.harm_en ? OP_SIN0 : OP_ERR;
               end
            end
            ST_RUN: begin
               if (!stall) begin
                  op_ff   <= op_in;
                  hsel_ff <= hsel_in;
                  if (op_ff == OP_DMP_GET) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign cmd.load   = accept;
   assign cmd.fire   = (state_ff == ST_RUN) && !stall;
   assign cmd.op     = op_ff;
   assign cmd.hsel   = hsel_ff;

endmodule

`default_nettype wire

>>> design/predictive_pfc_duty_controller.sv
// ----------------------------------------------------------------------------
// predictive_pfc_duty_controller
// Boost-PFC duty command: feedforward, proportional and damping terms.
// ----------------------------------------------------------------------------
// Flow: one transaction at a time; a new one is accepted only once the
// previous one has run its three divides on the shared radix-4 divider and
// registered its result. A new transaction is taken while a result waits;
// the next result holds until it leaves.
// Reset: synchronous; configuration registers return to defaults, angle history clears.
`default_nettype none

module predictive_pfc_duty_controller
   import ppfc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   // inductor_current, current_ref, input_voltage, output_voltage, grid_angle
   input  wire logic [REQ_W-1:0]     req_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // duty
   output logic [DUTY_W-1:0]         rsp_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [RATIO_W-1:0]   csr_wdata
);

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ratio   <= 32'h0001_0000;
         cfg_ff.amp3    <= '0;
         cfg_ff.amp5    <= '0;
         cfg_ff.amp7    <= '0;
         cfg_ff.phase3  <= '0;
         cfg_ff.phase5  <= '0;
         cfg_ff.phase7  <= '0;
         cfg_ff.harm_en <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATIO:   cfg_ff.ratio   <= csr_wdata;
            CSR_AMP3:    cfg_ff.amp3    <= csr_wdata[DATA_W-1:0];
            CSR_AMP5:    cfg_ff.amp5    <= csr_wdata[DATA_W-1:0];
            CSR_AMP7:    cfg_ff.amp7    <= csr_wdata[DATA_W-1:0];
            CSR_PHASE3:  cfg_ff.phase3  <= csr_wdata[ANGLE_W-1:0];
            CSR_PHASE5:  cfg_ff.phase5  <= csr_wdata[ANGLE_W-1:0];
            CSR_PHASE7:  cfg_ff.phase7  <= csr_wdata[ANGLE_W-1:0];
            CSR_HARM_EN: cfg_ff.harm_en <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   ppfc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ppfc_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .req_data   (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat)
   );

endmodule

`default_nettype wire

>>> test/predictive_pfc_duty_controller_test.sv
// ----------------------------------------------------------------------------
// predictive_pfc_duty_controller_test
// Drives samples in random bursts against a stalling receiver, predicts each
// duty command with an integer model of the controller and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module predictive_pfc_duty_controller_test
   import ppfc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0]        angle;
      logic signed [23:0] vout;
      logic signed [23:0] vin;
      logic signed [23:0] iref;
      logic signed [23:0] il;
   } sample_type;

   typedef struct {
      sample_type s;
      logic       has_duty;
      logic [31:0] duty;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DUTY_W-1:0]    rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_RATIO;
   logic [RATIO_W-1:0]   csr_wdata = '0;

   logic [31:0]        m_ratio;
   logic signed [23:0] m_amp [3];
   logic [15:0]        m_phase [3];
   logic               m_harm_en;
   logic [15:0]        m_prev_angle;
   logic               m_angle_seen;

   logic [31:0] duty_queue [$];
   int          error_count = 0;
   bit          stall_mode = 0;

   predictive_pfc_duty_controller uut (.*);

   always #5 clock = ~clock;

   function automatic longint floor_sh14(longint v);
      if (v >= 0) return v >>> 14;
      return -((-v + 16383) >>> 14);
   endfunction

   function automatic longint sine14(logic [15:0] a);
      longint z, z2, t, s;
      z = a[13:0];
      if (a[14]) z = 16384 - z;
      z2 = (z * z) >>> 14;
      t = 10512 - ((1160 * z2) >>> 14);
      t = 25736 - ((t * z2) >>> 14);
      s = (t * z) >>> 14;
      return a[15] ? -s : s;
   endfunction

   function automatic longint abs64(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic [31:0] predict_duty(sample_type s);
      longint il, vin, vo, ilsafe, ref_i, err, emag, dff, corr, damp, d, sum;
      longint h3, h5, h7;
      logic [15:0] lead;
      bit pos, epos;
      il = s.il; vin = s.vin;
      pos = vin > 0;
      if (!m_angle_seen) begin
         m_prev_angle = s.angle;
         m_angle_seen = 1;
      end
      vo = abs64(longint'(s.vout));
      if (vo < 4096) vo = 4096;
      ilsafe = abs64(il);
      if (ilsafe < 1) ilsafe = 1;
      ref_i = pos ? abs64(longint'(s.iref)) : -abs64(longint'(s.iref));
      if (m_harm_en) begin
         lead = s.angle + (s.angle - m_prev_angle);
         m_prev_angle = s.angle;
         h3 = abs64(longint'(m_amp[0])) * sine14(16'(3 * lead + m_phase[0]));
         h5 = abs64(longint'(m_amp[1])) * sine14(16'(5 * lead + m_phase[1]));
         h5 = floor_sh14(h5 * 17695);
         h7 = abs64(longint'(m_amp[2])) * sine14(16'(7 * lead + m_phase[2]));
         sum = h3 + h5 + h7;
         ref_i -= floor_sh14(sum);
      end
      err = ref_i - il;
      emag = abs64(err);
      epos = (err >= 0) == pos;
      dff = (longint'(1) << 24) - ((abs64(vin) << 24) / vo);
      corr = (longint'(m_ratio) * emag) / vo;
      corr = (corr * 22938) >>> 8;
      if (!epos) corr = -corr;
      damp = (emag * 251658) / ilsafe;
      if (!epos) damp = -damp;
      d = dff + corr + damp;
      if (d > 64'sh7FFFFFFF) d = 64'sh7FFFFFFF;
      if (d < -64'sh80000000) d = -64'sh80000000;
      return d[31:0];
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RATIO:   m_ratio = val;
         CSR_AMP3:    m_amp[0] = val[23:0];
         CSR_AMP5:    m_amp[1] = val[23:0];
         CSR_AMP7:    m_amp[2] = val[23:0];
         CSR_PHASE3:  m_phase[0] = val[15:0];
         CSR_PHASE5:  m_phase[1] = val[15:0];
         CSR_PHASE7:  m_phase[2] = val[15:0];
         CSR_HARM_EN: m_harm_en = val[0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (duty_queue.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic send(sample_type s, logic has_duty, logic [31:0] duty);
      logic [31:0] p;
      p = predict_duty(s);
      if (has_duty && p !== duty) begin
         $display("%0t table mismatch: expected %h actual %h", $time, duty, p);
         error_count++;
      end
      if (has_duty) p = duty;
      req_tvalid <= 1'b1;
      req_tdata <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      duty_queue.push_back(p);
   endtask

   function automatic sample_type rand_sample();
      sample_type s;
      s.angle = 16'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            s.il = 24'($urandom); s.iref = 24'($urandom);
            s.vin = 24'($urandom); s.vout = 24'($urandom);
         end
         default: begin
            s.il = 24'(int'($urandom_range(0, 80000)) - 40000);
            s.iref = 24'(int'($urandom_range(0, 80000)) - 40000);
            s.vin = 24'(int'($urandom_range(0, 3000000)) - 1500000);
            s.vout = 24'(int'($urandom_range(0, 3200000)) - 1600000);
         end
      endcase
      return s;
   endfunction

   task automatic send_burst(int n);
      int left;
      left = n;
      while (left > 0) begin
         int b;
         b = $urandom_range(1, 12);
         for (int k = 0; k < b && left > 0; k++) begin
            send(rand_sample(), 1'b0, '0);
            left--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 200)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (duty_queue.size() == 0) begin
               $display("%0t unexpected duty: expected none actual %h",
                        $time, rsp_tdata);
               error_count++;
            end else begin
               logic [31:0] e;
               e = duty_queue.pop_front();
               if (rsp_tdata !== e) begin
                  $display("%0t duty mismatch: expected %h actual %h",
                           $time, e, rsp_tdata);
                  error_count++;
               end
            end
         end
         if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
         rsp_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   row_type rows [$];

   initial begin
      sample_type s;
      m_ratio = 32'd65536;
      m_amp = '{default: '0};
      m_phase = '{default: '0};
      m_harm_en = 0;
      m_prev_angle = '0;
      m_angle_seen = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero everything: feedforward 1.0, err 0
      rows.push_back('{'{16'h1234, 24'sd0, 24'sd0, 24'sd0, 24'sd0}, 1'b1, 32'h01000000});
      // Vin equal to Vo: feedforward 0
      rows.push_back('{'{16'h0, 24'sd4096, 24'sd4096, 24'sd0, 24'sd0}, 1'b1, 32'h0});
      // large error, tiny iL: saturates high
      rows.push_back('{'{16'hFFFF, 24'sd0, 24'sd100, 24'sd8388607, 24'sd0}, 1'b1,
                       32'h7FFFFFFF});
      rows.push_back('{'{16'h8000, 24'sd0, -24'sd8388608, 24'sd0, 24'sd1}, 1'b0, '0});
      rows.push_back('{'{16'h4000, -24'sd8388608, 24'sd8388607, -24'sd8388608,
                       24'sd8388607}, 1'b0, '0});
      rows.push_back('{'{16'hC000, 24'sd8388607, -24'sd8388608, 24'sd8388607,
                       -24'sd8388608}, 1'b0, '0});
      rows.push_back('{'{16'h0001, 24'sd2048, 24'sd1, -24'sd1, -24'sd1}, 1'b0, '0});
      foreach (rows[i]) send(rows[i].s, rows[i].has_duty, rows[i].duty);
      req_tvalid <= 1'b0;
      drain();

      write_reg(CSR_AMP3, 32'h7FFFFF);
      write_reg(CSR_AMP5, 32'h800000);
      write_reg(CSR_AMP7, 32'h001000);
      write_reg(CSR_PHASE3, 32'hFFFF);
      write_reg(CSR_PHASE5, 32'h0);
      write_reg(CSR_PHASE7, 32'h4000);
      write_reg(CSR_RATIO, 32'hFFFFFFFF);
      write_reg(CSR_HARM_EN, 32'h1);
      // half-turn step and wrap of the angle
      for (int k = 0; k < 6; k++) begin
         s = rand_sample();
         s.angle = (k % 2) ? 16'h8000 : 16'(16'hFFFF - k);
         send(s, 1'b0, '0);
      end
      send_burst(200);
      drain();

      write_reg(CSR_RATIO, 32'h1);
      write_reg(CSR_HARM_EN, 32'h0);
      send_burst(200);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         write_reg(CSR_RATIO, $urandom_range(1, 32'h00100000));
         write_reg(CSR_AMP3, $urandom);
         write_reg(CSR_AMP5, $urandom);
         write_reg(CSR_AMP7, $urandom);
         write_reg(CSR_PHASE3, $urandom);
         write_reg(CSR_PHASE5, $urandom);
         write_reg(CSR_PHASE7, $urandom);
         write_reg(CSR_HARM_EN, 32'(ph != 1));
         send_burst(210);
         drain();
      end

      if (error_count == 0)
         $display("predictive_pfc_duty_controller_test: clean");
      else
         $display("predictive_pfc_duty_controller_test: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("predictive_pfc_duty_controller_test: errors");
      $finish;
   end

endmodule

`default_nettype wire
